FILE: hw/rtl/bsnl_pkg.sv
// ----------------------------------------------------------------------------
// bsnl_pkg: shared types and constants of the sorted neighbor list insert
// Field widths, the stored entry layout and the decision record passed from
// the locate stage to the row builder.
// ----------------------------------------------------------------------------
package bsnl_pkg;

   localparam int NODE_COUNT_DEF = 1024;
   localparam int LIST_DEPTH_DEF = 32;

   localparam int MODE_W  = 1;
   localparam int NODE_W  = 10;
   localparam int ID_W    = 10;
   localparam int KEY_W   = 32;
   localparam int SLOT_W  = 5;
   localparam int CNT_W   = 6;
   // Positions 0..64 cover every list depth the block supports.
   localparam int POS_W   = 7;
   localparam int ENTRY_W = ID_W + KEY_W;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

   localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
   localparam logic [MODE_W-1:0] MODE_READ   = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] wslot;
      logic [POS_W-1:0] top;
      logic [CNT_W-1:0] new_count;
   } decision_type;

endpackage

FILE: hw/rtl/bsnl_ram.sv
// ----------------------------------------------------------------------------
// bsnl_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module bsnl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bsnl_locate.sv
// ----------------------------------------------------------------------------
// bsnl_locate: compare and decide stages of an insert
// Compares the candidate against every entry of the fetched row, then finds
// the insert position, checks for a duplicate id among equal keys and
// decides whether the candidate is written.
// ----------------------------------------------------------------------------
module bsnl_locate #(
   parameter int LIST_DEPTH = bsnl_pkg::LIST_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 cmp_en,
   input  logic                                 dec_en,
   input  bsnl_pkg::entry_type [LIST_DEPTH-1:0] row,
   input  logic [bsnl_pkg::ID_W-1:0]            cand_id,
   input  logic [bsnl_pkg::KEY_W-1:0]           cand_key,
   input  logic [bsnl_pkg::CNT_W-1:0]           count,
   input  logic [bsnl_pkg::POS_W-1:0]           limit,
   output bsnl_pkg::decision_type               decision
);
   import bsnl_pkg::*;

   logic [LIST_DEPTH-1:0] le_in, le_ff;
   logic [LIST_DEPTH-1:0] lt_in, lt_ff;
   logic [LIST_DEPTH-1:0] eq_in, eq_ff;
   logic [POS_W-1:0]      n_in, n_ff;
   logic                  full_in, full_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [POS_W-1:0]      pos_i;
   logic [POS_W-1:0]      pos_lo;
   logic [POS_W-1:0]      top;
   logic                  over_last;
   logic                  dup;
   logic                  reject_far;
   decision_type          decision_in, decision_ff;

   // Compare stage: one comparator pair and one id match per slot.
   always_comb begin
      n_in    = (POS_W'(count) < limit) ? POS_W'(count) : limit;
      full_in = POS_W'(count) >= limit;
      for (int j = 0; j < LIST_DEPTH; j++) begin
         le_in[j] = (POS_W'(j) < n_in) && (row[j].key <= cand_key);
         lt_in[j] = row[j].key < cand_key;
         eq_in[j] = row[j].id == cand_id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         le_ff   <= le_in;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
         n_ff    <= n_in;
         full_ff <= full_in;
         cnt_ff  <= count;
      end
   end

   // Decide stage. The insert position is one past the highest slot below n
   // whose key does not exceed the candidate; the duplicate window is the
   // run of slots just below it whose keys are not below the candidate.
   always_comb begin
      pos_i     = '0;
      pos_lo    = '0;
      over_last = 1'b0;
      dup       = 1'b0;
      for (int j = 0; j < LIST_DEPTH; j++) begin
         if (le_ff[j]) begin
            pos_i = POS_W'(j + 1);
         end
         if (POS_W'(j + 1) == n_ff) begin
            over_last = lt_ff[j];
         end
      end
      for (int j = 0; j < LIST_DEPTH; j++) begin
         if (lt_ff[j] && (POS_W'(j) < pos_i)) begin
            pos_lo = POS_W'(j + 1);
         end
      end
      for (int j = 0; j < LIST_DEPTH; j++) begin
         if (eq_ff[j] && (POS_W'(j) >= pos_lo) && (POS_W'(j) < pos_i)) begin
            dup = 1'b1;
         end
      end
      reject_far = (cnt_ff != '0) && full_ff && over_last;
      // A full list shifts no further than its last slot within the limit.
      top = full_ff ? (n_ff - POS_W'(1)) : POS_W'(cnt_ff);
      decision_in.ok        = !reject_far && !dup;
      decision_in.wslot     = (pos_i < top) ? pos_i : top;
      decision_in.top       = top;
      decision_in.new_count = (decision_in.ok && !full_ff) ? (cnt_ff + CNT_W'(1)) : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (dec_en) begin
         decision_ff <= decision_in;
      end
   end

   assign decision = decision_ff;

endmodule

FILE: hw/rtl/bsnl_row_build.sv
// ----------------------------------------------------------------------------
// bsnl_row_build: builds the updated list row
// Writes the candidate at the chosen slot and moves the entries between that
// slot and the top of the shift window down by one.
// ----------------------------------------------------------------------------
module bsnl_row_build #(
   parameter int LIST_DEPTH = bsnl_pkg::LIST_DEPTH_DEF
) (
   input  bsnl_pkg::entry_type [LIST_DEPTH-1:0] row_in,
   input  bsnl_pkg::entry_type                  cand,
   input  bsnl_pkg::decision_type               decision,
   output bsnl_pkg::entry_type [LIST_DEPTH-1:0] row_out
);
   import bsnl_pkg::*;

   for (genvar p = 0; p < LIST_DEPTH; p++) begin : g_slot
      localparam logic [POS_W-1:0] PosIdx = POS_W'(p);
      if (p == 0) begin : g_first
         assign row_out[p] = (decision.wslot == PosIdx) ? cand : row_in[p];
      end else begin : g_rest
         assign row_out[p] =
            (decision.wslot == PosIdx) ? cand :
            ((PosIdx > decision.wslot) && (PosIdx <= decision.top)) ? row_in[p-1] :
            row_in[p];
      end
   end

endmodule

FILE: hw/rtl/bounded_sorted_neighbor_list_insert.sv
// ----------------------------------------------------------------------------
// bounded_sorted_neighbor_list_insert: per-node sorted neighbor lists
// Keeps one list per node in ascending key order with its entry count,
// inserts candidate neighbors under a programmable limit and reads back
// single entries.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  req_tdata, req_tuser (mode)
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata
//   csr_     in         csr_valid/csr_ready    csr_data (list_limit)
//
// A beat is accepted with the row and count reads issued, then compared
// against the fetched row, decided, and finally written back while the
// result register is loaded. After reset the count memory is cleared one
// node per cycle with req_tready low; csr writes are taken throughout. A
// result waiting on rsp_tready does not block the next accept; only the
// write-back of that next beat waits for the result register to free up.
//
module bounded_sorted_neighbor_list_insert #(
   parameter int NODE_COUNT = bsnl_pkg::NODE_COUNT_DEF,
   parameter int LIST_DEPTH = bsnl_pkg::LIST_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node [9:0], neighbor_id [19:10], distance_key [51:20], read_slot [56:52]
   input  logic [bsnl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode [0]
   input  logic [bsnl_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // inserted [0], written_slot [5:1], list_count [11:6], entry_id [21:12],
   // entry_distance [53:22]
   output logic [bsnl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bsnl_pkg::CNT_W-1:0]        csr_data
);
   import bsnl_pkg::*;

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int ROW_W   = LIST_DEPTH * ENTRY_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;

   // Request fields.
   logic [NODE_W-1:0]  req_node;
   logic [ID_W-1:0]    req_id;
   logic [KEY_W-1:0]   req_key;
   logic [SLOT_W-1:0]  req_slot;
   logic               req_accept;

   // Captured beat.
   logic [MODE_W-1:0]  mode_ff;
   logic [NODE_AW-1:0] node_addr_ff;
   logic               node_ok_ff;
   logic [ID_W-1:0]    cand_id_ff;
   logic [KEY_W-1:0]   cand_key_ff;
   logic [SLOT_W-1:0]  rd_slot_ff;

   // Read-mode result and count captured while the row is on the RAM output.
   logic [ID_W-1:0]    rd_id_in, rd_id_ff;
   logic [KEY_W-1:0]   rd_key_in, rd_key_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [CNT_W-1:0]   limit_ff;
   logic [POS_W-1:0]   eff_limit;

   logic               clr_busy_ff;
   logic [NODE_AW-1:0] clr_addr_ff;

   logic [ROW_W-1:0]   row_rd_flat, row_wr_flat;
   entry_type [LIST_DEPTH-1:0] row_rd, row_wr;
   logic [CNT_W-1:0]   cnt_rd;
   entry_type          cand;
   decision_type       decision;

   logic               out_free;
   logic               commit;
   logic               row_we;
   logic               cnt_we;
   logic [NODE_AW-1:0] cnt_wr_addr;
   logic [CNT_W-1:0]   cnt_wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  res_inserted;
   logic [SLOT_W-1:0]     res_slot;
   logic [CNT_W-1:0]      res_count;
   logic [ID_W-1:0]       res_id;
   logic [KEY_W-1:0]      res_key;

   assign req_node = req_tdata[NODE_W-1:0];
   assign req_id   = req_tdata[NODE_W+ID_W-1:NODE_W];
   assign req_key  = req_tdata[NODE_W+ID_W+KEY_W-1:NODE_W+ID_W];
   assign req_slot = req_tdata[NODE_W+ID_W+KEY_W+SLOT_W-1:NODE_W+ID_W+KEY_W];

   assign req_tready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // The limit register acts as at least one and at most the list depth.
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = POS_W'(1);
      end else if (POS_W'(limit_ff) > POS_W'(LIST_DEPTH)) begin
         eff_limit = POS_W'(LIST_DEPTH);
      end else begin
         eff_limit = POS_W'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Count-memory clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + NODE_AW'(1);
         if (clr_addr_ff == NODE_AW'(NODE_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff      <= req_tuser;
         node_addr_ff <= NODE_AW'(req_node);
         node_ok_ff   <= int'(req_node) < NODE_COUNT;
         cand_id_ff   <= req_id;
         cand_key_ff  <= req_key;
         rd_slot_ff   <= req_slot;
      end
   end

   // Row memory: a whole list per word.
   bsnl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODE_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (node_addr_ff),
      .wr_data (row_wr_flat),
      .rd_en   (req_accept),
      .rd_addr (NODE_AW'(req_node)),
      .rd_data (row_rd_flat)
   );

   // Count memory: shares its write port with the clearing pass.
   bsnl_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NODE_COUNT)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (req_accept),
      .rd_addr (NODE_AW'(req_node)),
      .rd_data (cnt_rd)
   );

   assign row_rd      = row_rd_flat;
   assign row_wr_flat = row_wr;
   assign cand.id     = cand_id_ff;
   assign cand.key    = cand_key_ff;

   bsnl_locate #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_locate (
      .clock    (clock),
      .cmp_en   (state_ff == ST_READ),
      .dec_en   (state_ff == ST_DECIDE),
      .row      (row_rd),
      .cand_id  (cand_id_ff),
      .cand_key (cand_key_ff),
      .count    (cnt_rd),
      .limit    (eff_limit),
      .decision (decision)
   );

   bsnl_row_build #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_row_build (
      .row_in   (row_rd),
      .cand     (cand),
      .decision (decision),
      .row_out  (row_wr)
   );

   // Read mode: pick the addressed entry when it lies below the count.
   always_comb begin
      rd_id_in  = '0;
      rd_key_in = '0;
      for (int j = 0; j < LIST_DEPTH; j++) begin
         if ((POS_W'(j) == POS_W'(rd_slot_ff)) && (POS_W'(rd_slot_ff) < POS_W'(cnt_rd))) begin
            rd_id_in  = row_rd[j].id;
            rd_key_in = row_rd[j].key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_id_ff  <= rd_id_in;
         rd_key_ff <= rd_key_in;
         cnt_ff    <= cnt_rd;
      end
   end

   // Write-back happens once, when the result register can take the beat.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == ST_WRITE) && out_free;
   assign row_we   = commit && node_ok_ff && (mode_ff == MODE_INSERT) && decision.ok;

   always_comb begin
      if (clr_busy_ff) begin
         cnt_we      = 1'b1;
         cnt_wr_addr = clr_addr_ff;
         cnt_wr_data = '0;
      end else begin
         cnt_we      = row_we;
         cnt_wr_addr = node_addr_ff;
         cnt_wr_data = decision.new_count;
      end
   end

   // Result fields; an out-of-range node gives an all-zero result.
   always_comb begin
      res_inserted = 1'b0;
      res_slot     = '0;
      res_count    = '0;
      res_id       = '0;
      res_key      = '0;
      if (node_ok_ff) begin
         if (mode_ff == MODE_INSERT) begin
            res_inserted = decision.ok;
            res_slot     = decision.ok ? decision.wslot[SLOT_W-1:0] : '0;
            res_count    = decision.new_count;
         end else begin
            res_count = cnt_ff;
            res_id    = rd_id_ff;
            res_key   = rd_key_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_key, res_id, res_count, res_slot, res_inserted});
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted beat always moves on to the row read.
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_READ))
      else $error("accepted beat did not enter the read state");

   // A written candidate lands inside the effective limit.
   a_wslot_in_limit: assert property (@(posedge clock) disable iff (reset)
      row_we |-> (decision.wslot < eff_limit))
      else $error("insert written beyond the list limit");

   // A written list is never empty afterwards.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      row_we |-> (decision.new_count != '0))
      else $error("insert left an empty count");

   // An insert changes a count by at most one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_we && !clr_busy_ff) |->
         ((decision.new_count == cnt_ff) || (decision.new_count == cnt_ff + CNT_W'(1))))
      else $error("count moved by more than one");

endmodule

FILE: bench/bounded_sorted_neighbor_list_insert_tb.sv
// ----------------------------------------------------------------------------
// bounded_sorted_neighbor_list_insert_tb: self-checking bench for the list
// Drives insert and read beats through the request stream and predicts
// every response with a behavioral copy of the per-node sorted lists, the
// counts and the limit register. Responses are checked field by field in
// order. A short directed part covers ordering, ties, duplicate rejection,
// full lists and the limit extremes. Random batches follow, mostly inserts
// on a few busy nodes so lists fill up, overflow and get shrunk under them.
// ----------------------------------------------------------------------------
module bounded_sorted_neighbor_list_insert_tb;
   import bsnl_pkg::*;

   localparam int NODES = NODE_COUNT_DEF;
   localparam int DEPTH = LIST_DEPTH_DEF;
   // The limit covers the clearing pass after reset and every beat's trip
   // through the block, plus sender gaps and receiver stalls; it is several
   // times the slowest correct run.
   localparam int CYCLE_LIMIT = 600000;
   localparam int BEAT_LATENCY = 4;

   // One response beat, unpacked from rsp_tdata.
   typedef struct packed {
      logic              inserted;
      logic [SLOT_W-1:0] written_slot;
      logic [CNT_W-1:0]  list_count;
      logic [ID_W-1:0]   entry_id;
      logic [KEY_W-1:0]  entry_distance;
   } neighbor_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // node [9:0], neighbor_id [19:10], distance_key [51:20], read_slot [56:52]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // mode [0]
   logic [MODE_W-1:0]     req_tuser = MODE_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // inserted [0], written_slot [5:1], list_count [11:6], entry_id [21:12],
   // entry_distance [53:22]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data = '0;

   // Shadow copy of the block's state as the bench expects it to be.
   logic [ID_W-1:0]  shadow_id    [NODES][DEPTH];
   logic [KEY_W-1:0] shadow_key   [NODES][DEPTH];
   logic [CNT_W-1:0] shadow_count [NODES];
   logic [CNT_W-1:0] shadow_limit;

   // Responses still owed by the block, oldest first.
   neighbor_rsp_type pending_rsp[$];

   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_run = 0;
   int stall_style = 0;

   bounded_sorted_neighbor_list_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("bounded_sorted_neighbor_list_insert_tb failed");
         $finish;
      end
   end

   // Receiver back-pressure. The style is redrawn after each run of random
   // length: always ready, coin-flip ready, or mostly stalled. Long runs of
   // the first style give stretches with no stalls at all.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_run   <= $urandom_range(16, 200);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_style)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // Response checker. Every accepted beat is matched against the oldest
   // prediction; a beat with nothing pending is a failure on its own.
   always @(posedge clock) begin
      neighbor_rsp_type got;
      neighbor_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.inserted       = rsp_tdata[0];
         got.written_slot   = rsp_tdata[5:1];
         got.list_count     = rsp_tdata[11:6];
         got.entry_id       = rsp_tdata[21:12];
         got.entry_distance = rsp_tdata[53:22];
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat 0x%h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.inserted !== want.inserted) begin
               $error("inserted: expected %0d, got %0d", want.inserted, got.inserted);
               mismatches++;
            end
            if (got.written_slot !== want.written_slot) begin
               $error("written_slot: expected %0d, got %0d",
                      want.written_slot, got.written_slot);
               mismatches++;
            end
            if (got.list_count !== want.list_count) begin
               $error("list_count: expected %0d, got %0d",
                      want.list_count, got.list_count);
               mismatches++;
            end
            if (got.entry_id !== want.entry_id) begin
               $error("entry_id: expected %0d, got %0d", want.entry_id, got.entry_id);
               mismatches++;
            end
            if (got.entry_distance !== want.entry_distance) begin
               $error("entry_distance: expected 0x%h, got 0x%h",
                      want.entry_distance, got.entry_distance);
               mismatches++;
            end
         end
      end
   end

   // Applies one request to the shadow lists and returns the response the
   // block must give. The limit saturates into 1..DEPTH. A list whose count
   // already exceeds the limit is treated as full at the limit, keeps the
   // entries past it and keeps its count.
   function automatic neighbor_rsp_type predict_neighbor_update(
      input logic [MODE_W-1:0] mode,
      input int                node,
      input logic [ID_W-1:0]   nid,
      input logic [KEY_W-1:0]  key,
      input int                slot
   );
      neighbor_rsp_type r;
      int  cnt;
      int  lim;
      int  n;
      int  i;
      int  l;
      int  j;
      bit  full;
      bit  ok;
      r   = '0;
      cnt = shadow_count[node];
      ok  = 1'b0;
      j   = 0;
      if (mode == MODE_READ) begin
         // Only slots below the count hold written entries; others read 0.
         if (slot < cnt && slot < DEPTH) begin
            r.entry_id       = shadow_id[node][slot];
            r.entry_distance = shadow_key[node][slot];
         end
      end else begin
         lim  = (shadow_limit == 0) ? 1 : ((shadow_limit > DEPTH) ? DEPTH : shadow_limit);
         n    = (cnt < lim) ? cnt : lim;
         full = (cnt >= lim);
         if (cnt == 0) begin
            shadow_id[node][0]  = nid;
            shadow_key[node][0] = key;
            cnt = 1;
            ok  = 1'b1;
         end else if (key > shadow_key[node][n-1]) begin
            // Beyond the last entry: append unless the list is full.
            if (!full) begin
               j = cnt;
               shadow_id[node][j]  = nid;
               shadow_key[node][j] = key;
               cnt++;
               ok = 1'b1;
            end
         end else begin
            // First slot with a strictly greater key; ties land after the
            // equal run, which is then searched for the same id.
            i = n;
            while (i > 0 && shadow_key[node][i-1] > key)
               i--;
            ok = 1'b1;
            l  = i;
            while (ok && l > 0 && shadow_key[node][l-1] >= key) begin
               if (shadow_id[node][l-1] == nid)
                  ok = 1'b0;
               l--;
            end
            if (ok) begin
               // A full list drops its last entry, or overwrites it on a tie.
               j = full ? n - 1 : cnt;
               while (j > i) begin
                  shadow_id[node][j]  = shadow_id[node][j-1];
                  shadow_key[node][j] = shadow_key[node][j-1];
                  j--;
               end
               shadow_id[node][j]  = nid;
               shadow_key[node][j] = key;
               if (!full)
                  cnt++;
            end
         end
         shadow_count[node] = CNT_W'(cnt);
         r.inserted     = ok;
         r.written_slot = SLOT_W'(j);
      end
      r.list_count = CNT_W'(cnt);
      return r;
   endfunction

   // Sends one request beat. The sender works in bursts; between bursts it
   // may drop tvalid for a random gap. Within a burst tvalid stays high from
   // one beat to the next, so every caller either sends again in the same
   // step or calls settle_idle, which lowers it.
   task automatic send_request(
      input logic [MODE_W-1:0] mode,
      input int                node,
      input int                nid,
      input logic [KEY_W-1:0]  key,
      input int                slot
   );
      int               gap;
      neighbor_rsp_type want_rsp;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, SLOT_W'(slot), key, ID_W'(nid), NODE_W'(node)};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      want_rsp = predict_neighbor_update(mode, node, ID_W'(nid), key, slot);
      pending_rsp.insert(pending_rsp.size(), want_rsp);
   endtask

   // Stops sending, waits until every response is back and lets the block
   // run out its pipeline.
   task automatic settle_idle(input int extra_cycles);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_list_limit(input logic [CNT_W-1:0] value);
      settle_idle(2 * BEAT_LATENCY);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      shadow_limit = value;
   endtask

   // Random beats. Most inserts go to a few busy nodes with keys from a
   // narrow span and ids from a small set, so lists fill up and ties and
   // duplicate ids are common. The rest use the full range of every field.
   task automatic run_random_batch(
      input int items,
      input int hot_base,
      input int hot_nodes,
      input int key_span
   );
      int               node;
      int               nid;
      int               slot;
      int               pick;
      logic [KEY_W-1:0] key;
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 9) == 0)
            node = $urandom_range(0, NODES - 1);
         else
            node = (hot_base + $urandom_range(0, hot_nodes - 1)) % NODES;
         nid = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 7)
                                          : $urandom_range(0, (1 << ID_W) - 1);
         pick = $urandom_range(0, 99);
         if (pick < 45)
            key = $urandom_range(0, key_span);
         else if (pick < 75)
            key = $urandom_range(0, key_span * 8);
         else if (pick < 93)
            key = $urandom;
         else if (pick < 96)
            key = '0;
         else
            key = '1;
         // Reads mostly land on or just past the stored entries.
         if ($urandom_range(0, 9) < 3)
            slot = $urandom_range(0, DEPTH - 1);
         else
            slot = $urandom_range(0, (shadow_count[node] < DEPTH) ? shadow_count[node]
                                                                 : DEPTH - 1);
         if ($urandom_range(0, 99) < 15)
            send_request(MODE_READ, node, $urandom_range(0, (1 << ID_W) - 1),
                         $urandom, slot);
         else
            send_request(MODE_INSERT, node, nid, key, $urandom_range(0, DEPTH - 1));
      end
   endtask

   // Ordering under the reset limit: first insert, append, insert at the
   // front, a tie that lands after its equal, a duplicate id on an equal key,
   // reads inside and past the list, and the extreme node, id and keys.
   task automatic test_insert_ordering;
      send_request(MODE_INSERT, 0, 1, 32'd100, 0);
      send_request(MODE_INSERT, 0, 2, 32'd200, 0);
      send_request(MODE_INSERT, 0, 3, 32'd50, 0);
      send_request(MODE_INSERT, 0, 4, 32'd100, 0);
      send_request(MODE_INSERT, 0, 1, 32'd100, 0);
      send_request(MODE_READ, 0, 0, '0, 2);
      send_request(MODE_READ, 0, 1023, '1, 31);
      send_request(MODE_INSERT, NODES - 1, 1023, 32'hFFFF_FFFF, 31);
      send_request(MODE_INSERT, NODES - 1, 0, 32'd0, 0);
      send_request(MODE_READ, NODES - 1, 0, '0, 1);
   endtask

   // A list of three: reject beyond a full list, replace the last entry on
   // a tie, reject the same id on that tie, and drop the last on a front
   // insert.
   task automatic test_full_list_rules;
      write_list_limit(CNT_W'(3));
      send_request(MODE_INSERT, 7, 1, 32'd10, 0);
      send_request(MODE_INSERT, 7, 2, 32'd20, 0);
      send_request(MODE_INSERT, 7, 3, 32'd30, 0);
      send_request(MODE_INSERT, 7, 4, 32'd40, 0);
      send_request(MODE_INSERT, 7, 9, 32'd30, 0);
      send_request(MODE_INSERT, 7, 9, 32'd30, 0);
      send_request(MODE_INSERT, 7, 5, 32'd5, 0);
      send_request(MODE_READ, 7, 0, '0, 2);
   endtask

   // A zero limit behaves as a limit of one.
   task automatic test_zero_limit;
      write_list_limit(CNT_W'(0));
      send_request(MODE_INSERT, 12, 1, 32'd5, 0);
      send_request(MODE_INSERT, 12, 2, 32'd6, 0);
      send_request(MODE_INSERT, 12, 2, 32'd5, 0);
      send_request(MODE_READ, 12, 0, '0, 0);
   endtask

   // Random traffic under a spread of limits, the extremes among them; the
   // all-ones value saturates to the list depth.
   task automatic test_random_under_limits;
      logic [CNT_W-1:0] limits [6];
      limits = '{CNT_W'(16), CNT_W'(1), CNT_W'(32), CNT_W'(63),
                 CNT_W'($urandom_range(2, 31)), CNT_W'($urandom_range(2, 31))};
      foreach (limits[p]) begin
         write_list_limit(limits[p]);
         run_random_batch(220, $urandom_range(0, NODES - 1), 6, 40);
      end
   endtask

   // Lists grown under a large limit, then the limit cut below their counts:
   // they must act full at the new limit and keep their counts.
   task automatic test_shrunk_lists;
      int hot_base;
      hot_base = $urandom_range(0, NODES - 1);
      write_list_limit(CNT_W'(32));
      run_random_batch(150, hot_base, 3, 200);
      write_list_limit(CNT_W'(4));
      run_random_batch(150, hot_base, 3, 200);
   endtask

   initial begin
      // The shadow copy starts from the block's reset state.
      foreach (shadow_count[i])
         shadow_count[i] = '0;
      shadow_limit = LIMIT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_insert_ordering();
      test_full_list_rules();
      test_zero_limit();
      test_random_under_limits();
      test_shrunk_lists();

      settle_idle(4 * BEAT_LATENCY);
      if (mismatches == 0)
         $display("bounded_sorted_neighbor_list_insert_tb passed");
      else
         $display("bounded_sorted_neighbor_list_insert_tb failed");
      $finish;
   end

endmodule
